// ===== rtl/wmfp_pkg.sv =====
// Shared types, constants and helpers for the management frame element parser.
package wmfp_pkg;

   localparam int SsidMax    = 32;
   localparam int LengthBits = 12;
   localparam int BankBits   = 1;
   localparam int SsidIdxBits = $clog2(SsidMax);
   localparam int MemAddrBits = BankBits + SsidIdxBits;

   localparam logic [LengthBits-1:0] LenMax = {LengthBits{1'b1}};

   localparam logic [7:0] SubBeacon   = 8'h80;
   localparam logic [7:0] SubProbeReq = 8'h40;
   localparam logic [7:0] SubProbeRsp = 8'h50;
   localparam logic [7:0] TagSsid     = 8'd0;
   localparam logic [7:0] TagDsParam  = 8'd3;
   localparam logic [7:0] TagRsn      = 8'd48;
   localparam logic [7:0] TagVendor   = 8'd221;
   localparam logic [7:0] Wpa3Akm     = 8'h08;
   localparam logic [LengthBits-1:0] StartBeacon = 36;
   localparam logic [LengthBits-1:0] StartOther  = 24;

   typedef enum logic [1:0] {
      PH_TAG  = 2'd0,
      PH_LEN  = 2'd1,
      PH_DATA = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      SEC_OPEN    = 3'd0,
      SEC_WEP     = 3'd1,
      SEC_WPA     = 3'd2,
      SEC_WPA2    = 3'd3,
      SEC_MIXED   = 3'd4,
      SEC_WPA3    = 3'd5,
      SEC_UNKNOWN = 3'd6
   } sec_type;

   typedef enum logic {
      CSR_MATCH_SECOND = 1'b0,
      CSR_MATCH_THIRD  = 1'b1
   } csr_idx_type;

   // SSID store write from the front end
   typedef struct packed {
      logic                   en;
      logic [MemAddrBits-1:0] addr;
      logic [7:0]             data;
   } mem_wr_type;

   // one finished frame waiting for the back end
   typedef struct packed {
      logic [BankBits-1:0] bank;
      logic [5:0]          ssid_len;
      logic [47:0]         bssid;
      logic                det;
      logic [7:0]          chan;
      logic [7:0]          rssi;
      logic [2:0]          sec;
   } job_type;

   function automatic logic [7:0] wpa_oui(input logic [1:0] idx);
      logic [7:0] r;
      case (idx)
         2'd0: r = 8'h00;
         2'd1: r = 8'h50;
         2'd2: r = 8'hF2;
         default: r = 8'h01;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/wmfp_if.sv =====
// Byte input and result channel interfaces.
interface wmfp_req_if;
   logic              valid;
   logic              ready;
   logic [7:0]        data_byte;
   logic [11:0]       frame_length;
   logic signed [7:0] signal_strength;
   logic [7:0]        receive_channel;
   logic              is_management;
   logic              end_of_frame;
   modport source (output valid, data_byte, frame_length, signal_strength,
                   receive_channel, is_management, end_of_frame, input ready);
   modport sink (input valid, data_byte, frame_length, signal_strength,
                 receive_channel, is_management, end_of_frame, output ready);
endinterface

interface wmfp_rsp_if;
   logic              valid;
   logic              ready;
   logic              record_kind;
   logic [7:0]        ssid_char;
   logic [5:0]        ssid_length;
   logic [47:0]       bssid_value;
   logic              detected;
   logic [7:0]        channel_number;
   logic signed [7:0] rssi_out;
   logic [2:0]        security_class;
   logic              run_last;
   modport source (output valid, record_kind, ssid_char, ssid_length, bssid_value,
                   detected, channel_number, rssi_out, security_class, run_last,
                   input ready);
   modport sink (input valid, record_kind, ssid_char, ssid_length, bssid_value,
                 detected, channel_number, rssi_out, security_class, run_last,
                 output ready);
endinterface

// ===== rtl/wmfp_front.sv =====
// Front end: per-byte header capture and tagged element walk.
module wmfp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           data_byte,
   input  logic [11:0]          frame_length,
   input  logic [7:0]           signal_strength,
   input  logic [7:0]           receive_channel,
   input  logic                 is_management,
   input  logic                 end_of_frame,
   input  logic [7:0]           match_second,
   input  logic [7:0]           match_third,
   output wmfp_pkg::mem_wr_type mem_wr,
   output logic                 job_push,
   output wmfp_pkg::job_type    job
);
   logic [11:0] pos_ff, pos_in, len_ff, len_in;
   logic [7:0]  sub_ff, sub_in, tag_ff, tag_in, rem_ff, rem_in, didx_ff, didx_in;
   logic [7:0]  chan_ff, chan_in, rssi_ff, rssi_in;
   logic [47:0] bssid_ff, bssid_in;
   logic        priv_ff, priv_in, stop_ff, stop_in, vm_ff, vm_in, mgmt_ff, mgmt_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [2:0]  flags_ff, flags_in;   // {wpa3, wpa, rsn}
   logic [0:0]  bank_ff, bank_in;
   wmfp_pkg::phase_type ph_ff, ph_in;

   logic        first;
   logic [11:0] wlen, start;
   logic [12:0] need;
   logic [8:0]  total;
   logic        sub_ok;
   logic [2:0]  sec;

   always_comb begin
      first = (pos_ff == '0);
      len_in   = first ? frame_length : len_ff;
      sub_in   = first ? {data_byte[7:4], 4'h0} : sub_ff;
      chan_in  = first ? receive_channel : chan_ff;
      rssi_in  = first ? signal_strength : rssi_ff;
      mgmt_in  = first ? is_management : mgmt_ff;
      bssid_in = first ? '0 : bssid_ff;
      priv_in  = first ? 1'b0 : priv_ff;
      stop_in  = first ? 1'b0 : stop_ff;
      vm_in    = first ? 1'b0 : vm_ff;
      cnt_in   = first ? '0 : cnt_ff;
      flags_in = first ? '0 : flags_ff;
      tag_in   = first ? '0 : tag_ff;
      rem_in   = first ? '0 : rem_ff;
      didx_in  = first ? '0 : didx_ff;
      ph_in    = first ? wmfp_pkg::PH_TAG : ph_ff;
      bank_in  = bank_ff;
      mem_wr   = '0;
      need     = '0;
      total    = '0;

      wlen = (len_in > 12'd4) ? len_in - 12'd4 : '0;
      if (pos_ff >= 12'd10 && pos_ff <= 12'd15) bssid_in = {bssid_in[39:0], data_byte};
      if (pos_ff == 12'd34) priv_in = data_byte[4];
      start = (sub_in == wmfp_pkg::SubBeacon) ? wmfp_pkg::StartBeacon
                                              : wmfp_pkg::StartOther;

      if (!stop_in && pos_ff >= start) begin
         case (ph_in)
            wmfp_pkg::PH_TAG: begin
               need = {1'b0, pos_ff} + 13'd2;
               if (need > {1'b0, wlen}) stop_in = 1'b1;
               else begin
                  tag_in = data_byte;
                  ph_in  = wmfp_pkg::PH_LEN;
               end
            end
            wmfp_pkg::PH_LEN: begin
               need = {1'b0, pos_ff} + 13'd1 + {5'd0, data_byte};
               if (need > {1'b0, wlen}) stop_in = 1'b1;
               else begin
                  rem_in  = data_byte;
                  didx_in = '0;
                  vm_in   = (tag_in == wmfp_pkg::TagVendor) && (data_byte >= 8'd4);
                  if (tag_in == wmfp_pkg::TagRsn) flags_in[0] = 1'b1;
                  if (tag_in == wmfp_pkg::TagSsid && data_byte >= 8'd1 &&
                      data_byte <= 8'(wmfp_pkg::SsidMax)) cnt_in = '0;
                  ph_in = (data_byte == 8'd0) ? wmfp_pkg::PH_TAG : wmfp_pkg::PH_DATA;
               end
            end
            default: begin
               total = {1'b0, didx_in} + {1'b0, rem_in};
               if (tag_in == wmfp_pkg::TagSsid && total >= 9'd1 &&
                   total <= 9'(wmfp_pkg::SsidMax) && didx_in < 8'(wmfp_pkg::SsidMax)) begin
                  mem_wr.en   = accept;
                  mem_wr.addr = {bank_ff, didx_in[wmfp_pkg::SsidIdxBits-1:0]};
                  mem_wr.data = data_byte;
                  if (rem_in == 8'd1) cnt_in = total[5:0];
               end
               if (tag_in == wmfp_pkg::TagDsParam && total == 9'd1) chan_in = data_byte;
               if (tag_in == wmfp_pkg::TagRsn && total >= 9'd10 && didx_in == 8'd9 &&
                   data_byte == wmfp_pkg::Wpa3Akm) flags_in[2] = 1'b1;
               if (tag_in == wmfp_pkg::TagVendor && vm_in && didx_in < 8'd4) begin
                  if (data_byte != wmfp_pkg::wpa_oui(didx_in[1:0])) vm_in = 1'b0;
                  else if (didx_in == 8'd3) flags_in[1] = 1'b1;
               end
               didx_in = didx_in + 8'd1;
               rem_in  = rem_in - 8'd1;
               if (rem_in == 8'd0) ph_in = wmfp_pkg::PH_TAG;
            end
         endcase
      end

      pos_in = (pos_ff < wmfp_pkg::LenMax) ? pos_ff + 12'd1 : pos_ff;

      sub_ok = (sub_in == wmfp_pkg::SubBeacon) || (sub_in == wmfp_pkg::SubProbeReq) ||
               (sub_in == wmfp_pkg::SubProbeRsp);
      if (sub_in != wmfp_pkg::SubBeacon) sec = wmfp_pkg::SEC_UNKNOWN;
      else if (wlen < 12'd36 || !priv_in) sec = wmfp_pkg::SEC_OPEN;
      else if (flags_in[2]) sec = wmfp_pkg::SEC_WPA3;
      else if (flags_in[0] && flags_in[1]) sec = wmfp_pkg::SEC_MIXED;
      else if (flags_in[0]) sec = wmfp_pkg::SEC_WPA2;
      else if (flags_in[1]) sec = wmfp_pkg::SEC_WPA;
      else sec = wmfp_pkg::SEC_WEP;

      job.bank     = bank_ff;
      job.ssid_len = cnt_in;
      job.bssid    = bssid_in;
      job.det      = mgmt_in && (len_in > 12'd4) && sub_ok && (pos_ff >= 12'd15) &&
                     (bssid_in[39:32] == match_second) && (bssid_in[31:24] == match_third);
      job.chan     = chan_in;
      job.rssi     = rssi_in;
      job.sec      = sec;
      job_push     = accept && end_of_frame;
      if (end_of_frame) begin
         pos_in  = '0;
         bank_in = ~bank_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; ph_ff <= wmfp_pkg::PH_TAG; stop_ff <= 1'b0; cnt_ff <= '0;
         flags_ff <= '0; vm_ff <= 1'b0; mgmt_ff <= 1'b0; bank_ff <= '0;
         len_ff <= '0; sub_ff <= '0; chan_ff <= '0; rssi_ff <= '0; bssid_ff <= '0;
         priv_ff <= 1'b0; tag_ff <= '0; rem_ff <= '0; didx_ff <= '0;
      end else if (accept) begin
         pos_ff <= pos_in; ph_ff <= ph_in; stop_ff <= stop_in; cnt_ff <= cnt_in;
         flags_ff <= flags_in; vm_ff <= vm_in; mgmt_ff <= mgmt_in; bank_ff <= bank_in;
         len_ff <= len_in; sub_ff <= sub_in; chan_ff <= chan_in; rssi_ff <= rssi_in;
         bssid_ff <= bssid_in; priv_ff <= priv_in; tag_ff <= tag_in; rem_ff <= rem_in;
         didx_ff <= didx_in;
      end
   end
endmodule

// ===== rtl/wmfp_queue.sv =====
// Two-entry queue of finished frames between front and back end.
module wmfp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  wmfp_pkg::job_type push_job,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output wmfp_pkg::job_type head
);
   wmfp_pkg::job_type slot_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      full      = (cnt_ff == 2'd2);
      not_empty = (cnt_ff != 2'd0);
      head      = slot_ff[rptr_ff];
      wptr_in   = push ? ~wptr_ff : wptr_ff;
      rptr_in   = pop ? ~rptr_ff : rptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0; rptr_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         wptr_ff <= wptr_in; rptr_ff <= rptr_in; cnt_ff <= cnt_in;
      end
      if (push) slot_ff[wptr_ff] <= push_job;
   end
endmodule

// ===== rtl/wmfp_back.sv =====
// Back end: SSID store and result beat sequencer with output register.
module wmfp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  wmfp_pkg::mem_wr_type mem_wr,
   input  logic                 job_valid,
   input  wmfp_pkg::job_type    job,
   output logic                 job_pop,
   wmfp_rsp_if.source           rsp
);
   logic [7:0] mem [2**wmfp_pkg::MemAddrBits];
   logic [7:0] rd_ff;
   logic [5:0] k_ff, k_in;
   logic       ov_ff, ov_in, load, is_ssid;
   logic       kind_ff;
   wmfp_pkg::job_type sum_ff;

   always_comb begin
      load    = job_valid && (!ov_ff || rsp.ready);
      is_ssid = (k_ff < job.ssid_len);
      job_pop = load && !is_ssid;
      k_in    = k_ff;
      ov_in   = ov_ff;
      if (load) begin
         ov_in = 1'b1;
         k_in  = is_ssid ? k_ff + 6'd1 : '0;
      end else if (rsp.ready) ov_in = 1'b0;

      rsp.valid          = ov_ff;
      rsp.record_kind    = kind_ff;
      rsp.run_last       = kind_ff;
      rsp.ssid_char      = kind_ff ? 8'd0 : rd_ff;
      rsp.ssid_length    = kind_ff ? sum_ff.ssid_len : '0;
      rsp.bssid_value    = kind_ff ? sum_ff.bssid : '0;
      rsp.detected       = kind_ff & sum_ff.det;
      rsp.channel_number = kind_ff ? sum_ff.chan : '0;
      rsp.rssi_out       = kind_ff ? sum_ff.rssi : '0;
      rsp.security_class = kind_ff ? sum_ff.sec : '0;
   end

   always_ff @(posedge clock) begin
      if (mem_wr.en) mem[mem_wr.addr] <= mem_wr.data;
      if (load && is_ssid) rd_ff <= mem[{job.bank, k_ff[wmfp_pkg::SsidIdxBits-1:0]}];
      if (load) begin
         kind_ff <= !is_ssid;
         sum_ff  <= job;
      end
      if (reset) begin
         ov_ff <= 1'b0; k_ff <= '0;
      end else begin
         ov_ff <= ov_in; k_ff <= k_in;
      end
   end
endmodule

// ===== rtl/wlan_mgmt_frame_ie_parser_unit.sv =====
// Top level of the 802.11 management frame information element parser.
// Usage:
//  - req_chan takes one frame byte per beat, starting at frame control. Length,
//    RSSI, channel and management flag are sampled on the first beat of a frame;
//    end_of_frame marks the last beat.
//  - After the last beat, rsp_chan gives one beat per recorded SSID byte and then
//    one summary beat (record_kind = run_last = 1).
//  - Throughput: one input beat per cycle while req ready is high. The front end
//    walks elements at the byte rate; the back end gives one result beat per cycle
//    while rsp ready is high. Results pass the frame queue and the output register.
//  - Two SSID banks and a two-deep frame queue decouple the halves: the front
//    end keeps taking bytes of the next frame while results drain. It stalls
//    (req ready low) only when two finished frames are still waiting.
//  - A stalled receiver holds rsp payload steady; the output register frees
//    as soon as it is taken.
//  - Synchronous reset clears the parse state, the queue and the output
//    register; match bytes return to 19 and 55.
//  - csr_ writes belong in idle periods only: no frame in progress, no result pending.
module wlan_mgmt_frame_ie_parser_unit (
   input  logic        clock,
   input  logic        reset,
   wmfp_req_if.sink    req_chan,
   wmfp_rsp_if.source  rsp_chan,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [7:0]  csr_write_data
);
   logic [7:0] match2_ff, match3_ff;
   logic       accept, q_full, q_ne, push, pop;
   wmfp_pkg::mem_wr_type mem_wr;
   wmfp_pkg::job_type    push_job, head;

   // hold off new bytes while both SSID banks are owned by queued frames
   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         match2_ff <= 8'd19;
         match3_ff <= 8'd55;
      end else if (csr_write_enable) begin
         case (csr_index)
            wmfp_pkg::CSR_MATCH_SECOND: match2_ff <= csr_write_data;
            wmfp_pkg::CSR_MATCH_THIRD:  match3_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   wmfp_front u_front (
      .clock, .reset, .accept,
      .data_byte       (req_chan.data_byte),
      .frame_length    (req_chan.frame_length),
      .signal_strength (req_chan.signal_strength),
      .receive_channel (req_chan.receive_channel),
      .is_management   (req_chan.is_management),
      .end_of_frame    (req_chan.end_of_frame),
      .match_second    (match2_ff),
      .match_third     (match3_ff),
      .mem_wr, .job_push (push), .job (push_job)
   );

   wmfp_queue u_queue (
      .clock, .reset, .push, .push_job, .pop,
      .full (q_full), .not_empty (q_ne), .head
   );

   wmfp_back u_back (
      .clock, .reset, .mem_wr,
      .job_valid (q_ne), .job (head), .job_pop (pop),
      .rsp (rsp_chan)
   );
endmodule
